>>> sv/hph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hph_pkg: shared types and code tables for the HPACK Huffman encoder
// Holds the channel payload structs, the queue entry and the static code and length ROMs.
// ----------------------------------------------------------------------------
package hph_pkg;

  localparam int CODE_W = 30;
  localparam int LEN_W  = 5;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_string;
  } hph_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } hph_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              eos;
  } hph_entry_t;

  localparam logic [CODE_W-1:0] CODE_ROM [256] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
    30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
    30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
    30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
    30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
    30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
    30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
    30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
    30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
    30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
    30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
    30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
    30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
    30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
    30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
    30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
    30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
    30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
    30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
    30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
    30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
    30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
    30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
    30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
    30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
    30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
    30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
    30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
    30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
    30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
    30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
    30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
    30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
    30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
    30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
    30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
    30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
    30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
    30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
    30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  localparam logic [LEN_W-1:0] LEN_ROM [256] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
    5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
    5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
    5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
    5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
    5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
    5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
    5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
    5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
    5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

endpackage

>>> sv/hph_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hph_front: symbol intake and code lookup
// Accepts one symbol per transfer, looks up its code and length, and holds
// the result in a stage register until the queue takes it.
// ----------------------------------------------------------------------------
module hph_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hph_pkg::hph_in_t    in_data,
  output logic                ent_valid,
  input  logic                ent_ready,
  output hph_pkg::hph_entry_t ent_data
);
  import hph_pkg::*;

  logic       valid_r;
  hph_entry_t entry_r;

  assign in_ready  = !valid_r || ent_ready;
  assign ent_valid = valid_r;
  assign ent_data  = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload: load on every transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry_r.code <= CODE_ROM[in_data.symbol];
      entry_r.len  <= LEN_ROM[in_data.symbol];
      entry_r.eos  <= in_data.end_of_string;
    end
  end

endmodule

>>> sv/hph_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hph_queue: two-entry queue between lookup and bit packer
// Decouples the lookup stage from the packer so each side stalls on its own.
// ----------------------------------------------------------------------------
module hph_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  hph_pkg::hph_entry_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output hph_pkg::hph_entry_t rd_data
);
  import hph_pkg::*;

  hph_entry_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/hph_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hph_back: bit packer and output register
// Appends codes to a bit accumulator, drains one byte per cycle unless the
// output stalls, pads the tail of a string with ones and marks its final byte.
// ----------------------------------------------------------------------------
module hph_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ent_valid,
  output logic                ent_ready,
  input  hph_pkg::hph_entry_t ent_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hph_pkg::hph_out_t   out_data
);
  import hph_pkg::*;

  // At most 7 leftover bits plus the longest code.
  localparam int ACC_W = 7 + CODE_W;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic             flush_r, flush_nxt, flush_after;
  logic             out_valid_r;
  hph_out_t         out_data_r;

  logic             slot_free;
  logic             have_full;
  logic             emit;
  logic             pop;
  logic [2:0]       pad_amt;
  logic [7:0]       full_byte;
  logic [7:0]       pad_byte;
  hph_out_t         emit_data;

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    have_full = (cnt_r >= CNT_W'(8));
    emit      = slot_free && (have_full || (flush_r && (cnt_r != '0)));

    // Bits live right-aligned in acc_r[cnt_r-1:0]; the oldest bits are on top.
    full_byte = 8'(acc_r >> (cnt_r - CNT_W'(8)));
    pad_amt   = 3'(CNT_W'(8) - cnt_r);
    pad_byte  = 8'(acc_r << pad_amt) | ~(8'hFF << pad_amt);

    if (have_full) begin
      emit_data.out_byte  = full_byte;
      emit_data.last_byte = flush_r && (cnt_r == CNT_W'(8));
    end else begin
      emit_data.out_byte  = pad_byte;
      emit_data.last_byte = 1'b1;
    end

    if (!emit) begin
      cnt_after = cnt_r;
    end else if (have_full) begin
      cnt_after = cnt_r - CNT_W'(8);
    end else begin
      cnt_after = '0;
    end
    flush_after = flush_r && !(emit && emit_data.last_byte);

    // Take the next code once fewer than 8 bits remain and no flush is due.
    pop = ent_valid && (cnt_after < CNT_W'(8)) && !flush_after;

    if (pop) begin
      acc_nxt   = (acc_r << ent_data.len) | ACC_W'(ent_data.code);
      cnt_nxt   = cnt_after + CNT_W'(ent_data.len);
      flush_nxt = ent_data.eos;
    end else begin
      acc_nxt   = acc_r;
      cnt_nxt   = cnt_after;
      flush_nxt = flush_after;
    end
  end

  assign ent_ready = (cnt_after < CNT_W'(8)) && !flush_after;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

endmodule

>>> sv/hpack_huffman_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_huffman_encoder: static HPACK Huffman encoder, top level
// Encodes a header string byte by byte into packed Huffman-coded bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one string byte per transfer; end_of_string marks its final byte.
//   out_* : encoded bytes, first code bit in the MSB; last_byte marks the
//           final byte of a string, whose unused low bits are padded with ones.
//   Both channels use valid/ready; a transfer happens when both are high.
// Path: a symbol passes the lookup register and then the queue before it
//   reaches the packer; the first byte it completes goes through the
//   accumulator and the output register before it appears on out_*.
// Throughput: one symbol per cycle while out_ready is high and the codes
//   average no more than eight bits, since the packer drains one byte per
//   cycle; a long code holds the input until its bytes are out. A string
//   that ends in a partial byte does not hold up the next symbol: the padded
//   byte leaves in the same cycle in which the packer takes the next symbol.
// Reset: clears the lookup register, the queue and the packer, so the next
//   symbol starts a fresh string. When out_ready is low the finished byte
//   holds in the output register, the packer and queue fill, and in_ready
//   drops once the lookup register cannot drain.
// ----------------------------------------------------------------------------
module hpack_huffman_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hph_pkg::hph_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hph_pkg::hph_out_t out_data
);
  import hph_pkg::*;

  // Lookup stage to queue.
  logic       lk_valid;
  logic       lk_ready;
  hph_entry_t lk_data;

  // Queue to packer.
  logic       q_valid;
  logic       q_ready;
  hph_entry_t q_data;

  // Front: take the symbol and fetch its code and length.
  hph_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ent_valid (lk_valid),
    .ent_ready (lk_ready),
    .ent_data  (lk_data)
  );

  // Hold up to two looked-up codes while the packer drains bytes.
  hph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (lk_valid),
    .wr_ready (lk_ready),
    .wr_data  (lk_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Back: pack code bits into bytes and drive the result channel.
  hph_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .ent_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/hph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hph_checker: scoreboard for the HPACK Huffman encoder
// Watches both channels, packs each accepted symbol into expected bytes and
// compares every output transfer against the oldest expected byte.
// ----------------------------------------------------------------------------
module hph_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  hph_pkg::hph_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  hph_pkg::hph_out_t out_data,
  output int                fail_count,
  output int                bytes_left,
  output int                bytes_checked
);
  import hph_pkg::*;

  // Code lengths of the static HPACK table; the codes themselves are canonical
  // and are rebuilt from these lengths below.
  localparam int CODE_LEN [256] = '{
    13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
    28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
     6, 10, 10, 12, 13,  6,  8, 11, 10, 10,  8, 11,  8,  6,  6,  6,
     5,  5,  5,  6,  6,  6,  6,  6,  6,  6,  7,  8, 15,  6, 12, 10,
    13,  6,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,  7,
     7,  7,  7,  7,  7,  7,  7,  7,  8,  7,  8, 13, 19, 13, 14,  6,
    15,  5,  6,  5,  6,  5,  6,  6,  6,  5,  7,  7,  6,  6,  6,  5,
     6,  7,  6,  5,  5,  6,  7,  7,  7,  7,  7, 15, 11, 14, 13, 28,
    20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
    24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
    22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
    21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
    26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
    19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
    20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
    26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
  };

  logic [29:0] huff_code [256];
  logic [7:0]  pend_byte;
  logic [2:0]  fill_pos;
  hph_out_t    expected_bytes [$];
  hph_out_t    want;

  // Assign codes in order of length, then symbol value.
  initial begin : build_codes
    logic [29:0] next_code;
    next_code = '0;
    for (int l = 5; l <= 30; l++) begin
      for (int s = 0; s < 256; s++) begin
        if (CODE_LEN[s] == l) begin
          huff_code[s] = next_code;
          next_code++;
        end
      end
      next_code = next_code << 1;
    end
  end

  task automatic encode_symbol(input hph_in_t item);
    logic [29:0] code;
    hph_out_t    tail;
    int          n;
    code = huff_code[item.symbol];
    n = 0;
    for (int k = CODE_LEN[item.symbol] - 1; k >= 0; k--) begin
      if (!code[k]) pend_byte[fill_pos] = 1'b0;
      if (fill_pos == 3'd0) begin
        expected_bytes.push_back('{out_byte: pend_byte, last_byte: 1'b0});
        n++;
        pend_byte = 8'hFF;
        fill_pos  = 3'd7;
      end else begin
        fill_pos--;
      end
    end
    if (item.end_of_string) begin
      // flush a partial byte; its unused low bits are still ones
      if (fill_pos != 3'd7) begin
        expected_bytes.push_back('{out_byte: pend_byte, last_byte: 1'b0});
        n++;
      end
      if (n > 0) begin
        tail = expected_bytes.pop_back();
        tail.last_byte = 1'b1;
        expected_bytes.push_back(tail);
      end
      pend_byte = 8'hFF;
      fill_pos  = 3'd7;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pend_byte     = 8'hFF;
      fill_pos      = 3'd7;
      fail_count    = 0;
      bytes_checked = 0;
      expected_bytes.delete();
    end else begin
      if (in_valid && in_ready) encode_symbol(in_data);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, got %02h last %b",
                   $time, out_data.out_byte, out_data.last_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, want.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch: expected %b, got %b (byte %02h)",
                     $time, want.last_byte, out_data.last_byte, want.out_byte);
            fail_count++;
          end
          bytes_checked++;
        end
      end
    end
    bytes_left = expected_bytes.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for the HPACK Huffman encoder
// Drives header strings into the encoder, throttles both channels, forces
// backpressure and drain pauses, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
  import hph_pkg::*;

  localparam int RX_HOLD_CYCLES = 200;      // long receiver hold-off
  localparam int SETTLE_CYCLES  = 8;        // lookup, queue, packer, output reg
  localparam int LIMIT_CYCLES   = 1000000;
  localparam int RANDOM_TARGET  = 320;      // symbols sent before the final drain

  typedef enum int {MIX_TEXT, MIX_ANY, MIX_LONG} sym_mix_e;

  // Corner strings: {symbol, end_of_string}
  localparam logic [8:0] CORNER_ITEMS [22] = '{
    {8'd0,   1'b1},   // 13-bit code alone, padded
    {8'd48,  1'b1},   // shortest code, all zero bits
    {8'd10,  1'b1},   // 30-bit codes, then 255 with a 26-bit code
    {8'd13,  1'b1},
    {8'd22,  1'b1},
    {8'd255, 1'b1},
    {8'd38,  1'b1},   // exactly one byte, so no padding byte
    {8'd48,  1'b0},   // no byte completes on this transfer
    {8'd49,  1'b0},
    {8'd32,  1'b1},   // string ends right on a byte boundary
    {8'd58,  1'b0},   // leave seven bits pending ...
    {8'd10,  1'b1},   // ... then a 30-bit code: five bytes from one symbol
    {8'd1,   1'b0},
    {8'd128, 1'b0},
    {8'd127, 1'b0},
    {8'd254, 1'b1},
    {8'd126, 1'b0},
    {8'd92,  1'b0},
    {8'd200, 1'b1},
    {8'd101, 1'b0},
    {8'd116, 1'b0},
    {8'd97,  1'b1}
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  hph_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  hph_out_t out_data;

  int fail_count;
  int bytes_left;
  int bytes_checked;
  int symbols_sent;
  int strings_sent;
  bit tx_throttle;
  bit rx_throttle;
  bit rx_long_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hpack_huffman_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hph_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .bytes_left    (bytes_left),
    .bytes_checked (bytes_checked)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_symbol(input sym_mix_e mix);
    case (mix)
      MIX_TEXT: return 8'($urandom_range(32, 126));
      MIX_ANY:  return 8'($urandom_range(0, 255));
      default: begin
        // control characters and high bytes carry codes of 13 to 30 bits
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(128, 255));
      end
    endcase
  endfunction

  // Offer one symbol and hold it until the transfer. Called and returned at a
  // falling edge; valid stays high so the next symbol can follow directly.
  task automatic send_symbol(input logic [7:0] sym, input logic eos);
    if (tx_throttle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_data  <= '{symbol: sym, end_of_string: eos};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    symbols_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic send_string(input int len, input sym_mix_e mix);
    for (int i = 0; i < len; i++) send_symbol(pick_symbol(mix), i == len - 1);
  endtask

  task automatic send_random_strings(input int target);
    int       roll;
    sym_mix_e mix;
    while (symbols_sent < target) begin
      roll = $urandom_range(0, 9);
      mix  = (roll < 6) ? MIX_TEXT : (roll < 9) ? MIX_ANY : MIX_LONG;
      send_string($urandom_range(1, 10), mix);
    end
  endtask

  // Drop valid and hold off until every expected byte has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (bytes_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls while throttled, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_long_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    tx_throttle  = 1'b0;
    rx_throttle  = 1'b0;
    rx_long_hold = 1'b0;
    symbols_sent = 0;
    strings_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Corner strings back to back, no idling on either side.
    foreach (CORNER_ITEMS[i]) send_symbol(CORNER_ITEMS[i][8:1], CORNER_ITEMS[i][0]);

    // Random strings with gaps on both sides.
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    send_random_strings(140);

    // Hold the receiver and keep offering long codes so that the input stalls.
    tx_throttle  = 1'b0;
    rx_long_hold = 1'b1;
    send_random_strings(symbols_sent + 2);
    while (symbols_sent < 185) send_string($urandom_range(2, 8), MIX_LONG);
    wait_drained();

    // Fast sender against a stalling receiver, then full throttle again.
    send_random_strings(240);
    tx_throttle = 1'b1;
    send_random_strings(RANDOM_TARGET);
    wait_drained();

    $display("Encoded %0d symbols in %0d strings; %0d output bytes checked,",
             symbols_sent, strings_sent, bytes_checked);
    $display("covering corner codes, random gaps, a long output stall and drains.");
    if (fail_count == 0 && bytes_left == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles with %0d bytes still expected",
             LIMIT_CYCLES, bytes_left);
    $display("tb: failure");
    $finish;
  end

endmodule
